[hdl/slpg_pkg.sv]
`timescale 1ns / 1ps

package slpg_pkg;

	localparam int unsigned FADE_N = 1024;
	localparam int unsigned IDX_W = $clog2(FADE_N);
	localparam int unsigned ROM_DEPTH = FADE_N / 2 + 1;
	localparam int unsigned ROM_AW = $clog2(ROM_DEPTH);

	localparam int unsigned PER_W = 16;
	localparam int unsigned DIV_W = 32;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	localparam logic [PER_W-1:0] FAST_RST = 16'd200;
	localparam logic [PER_W-1:0] SLOW_RST = 16'd1000;
	localparam logic [PER_W-1:0] FADE_RST = 16'd4000;

	// configuration register indexes
	localparam logic [1:0] CFG_FAST = 2'd0;
	localparam logic [1:0] CFG_SLOW = 2'd1;
	localparam logic [1:0] CFG_FADE = 2'd2;

	// pattern chosen for the current item
	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_SOLID = 2'd1;
	localparam logic [1:0] MODE_BLINK = 2'd2;
	localparam logic [1:0] MODE_FADE = 2'd3;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_OVERRIDE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] now_ms;
		logic        starting_or_failed;
		logic        battery_charging;
		logic        usb_host_present;
		logic        battery_low;
		logic        link_connected;
		logic [30:0] override_duration_ms;
	} in_item_t;

	typedef struct packed {
		logic       drive_enable;
		logic [7:0] brightness;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel;
		logic save_phase;
		logic rom_rd;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       div_done;
		logic       out_free;
	} ctrl_sts_t;

	// raised-cosine level for folded table index m, evaluated at elaboration
	function automatic logic [7:0] fade_value(input int unsigned m_in);
		logic [63:0] n;
		logic [63:0] m;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] s;
		logic [63:0] q;
		longint sum;
		n = 64'(FADE_N);
		m = 64'(m_in);
		if (m > n) m = n;
		if (n - m < m) m = n - m;
		x = (64'(PI_Q30) * m) / 64'(FADE_N);
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k[0]) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
		s = 64'(sum);
		q = (s * s) >> 30;
		return 8'((q * 64'd255) >> 30);
	endfunction

endpackage

[hdl/slpg_div.sv]
`timescale 1ns / 1ps

module slpg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [slpg_pkg::DIV_W-1:0]    dividend,
	input  logic [slpg_pkg::PER_W-1:0]    divisor,
	output logic                          done,
	output logic [slpg_pkg::DIV_W-1:0]    quotient,
	output logic [slpg_pkg::PER_W-1:0]    remainder
);

	logic [slpg_pkg::PER_W-1:0]     rem_q;
	logic [slpg_pkg::DIV_W-1:0]     quo_q;
	logic [slpg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [slpg_pkg::PER_W:0]       trial;
	logic [slpg_pkg::PER_W:0]       diff;
	logic                           fits;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[slpg_pkg::DIV_W-1]};
	assign diff = trial - {1'b0, divisor};
	assign fits = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + slpg_pkg::DIV_CNT_W'(1);
				if (cnt_q == slpg_pkg::DIV_CNT_W'(slpg_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[slpg_pkg::PER_W-1:0] : trial[slpg_pkg::PER_W-1:0];
			quo_q <= {quo_q[slpg_pkg::DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

[hdl/slpg_datapath.sv]
`timescale 1ns / 1ps

module slpg_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  slpg_pkg::ctrl_cmd_t   cmd,
	output slpg_pkg::ctrl_sts_t   sts,
	input  slpg_pkg::in_item_t    in_data,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output slpg_pkg::out_item_t   out_data
);

	logic [slpg_pkg::PER_W-1:0] fast_q;
	logic [slpg_pkg::PER_W-1:0] slow_q;
	logic [slpg_pkg::PER_W-1:0] fadep_q;
	logic                       ovr_on_q;
	logic [31:0]                ovr_end_q;
	logic [31:0]                now_q;
	logic [1:0]                 mode_q;
	logic [1:0]                 mode_d;
	logic [slpg_pkg::PER_W-1:0] per_q;
	logic [slpg_pkg::PER_W-1:0] per_raw;
	logic [slpg_pkg::PER_W-1:0] phase_q;
	logic [7:0]                 fade_q;
	logic                       out_valid_q;
	slpg_pkg::out_item_t        out_q;
	slpg_pkg::out_item_t        result;
	logic [31:0]                expiry_diff;
	logic                       expired;
	logic [31:0]                scaled;
	logic [31:0]                div_dividend;
	logic                       div_done;
	logic [31:0]                div_quo;
	logic [slpg_pkg::PER_W-1:0] div_rem;
	logic [slpg_pkg::IDX_W-1:0] idx;
	logic [slpg_pkg::IDX_W-1:0] fold;
	logic [7:0]                 fade_rom [slpg_pkg::ROM_DEPTH];
	logic [7:0]                 level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q <= slpg_pkg::FAST_RST;
			slow_q <= slpg_pkg::SLOW_RST;
			fadep_q <= slpg_pkg::FADE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				slpg_pkg::CFG_FAST: fast_q <= cfg_data;
				slpg_pkg::CFG_SLOW: slow_q <= cfg_data;
				slpg_pkg::CFG_FADE: fadep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// wrap-safe: end reached when now - end is not negative
	assign expiry_diff = in_data.now_ms - ovr_end_q;
	assign expired = ~expiry_diff[31];

	always_comb begin
		mode_d = slpg_pkg::MODE_BLINK;
		per_raw = fast_q;
		if (in_data.operation == slpg_pkg::OP_OVERRIDE || ovr_on_q) begin
			mode_d = slpg_pkg::MODE_OFF;
		end else if (in_data.starting_or_failed) begin
			mode_d = slpg_pkg::MODE_BLINK;
		end else if (in_data.battery_charging || in_data.usb_host_present) begin
			mode_d = slpg_pkg::MODE_SOLID;
		end else if (in_data.battery_low) begin
			mode_d = slpg_pkg::MODE_FADE;
			per_raw = fadep_q;
		end else if (in_data.link_connected) begin
			per_raw = slow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_on_q <= 1'b0;
			ovr_end_q <= '0;
		end else if (cmd.load) begin
			if (in_data.operation == slpg_pkg::OP_OVERRIDE) begin
				ovr_on_q <= 1'b1;
				ovr_end_q <= in_data.now_ms + {1'b0, in_data.override_duration_ms};
			end else if (ovr_on_q && expired) begin
				ovr_on_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= in_data.now_ms;
			mode_q <= mode_d;
			per_q <= (per_raw == '0) ? slpg_pkg::PER_W'(1) : per_raw;
		end
		if (cmd.save_phase) begin
			phase_q <= div_rem;
		end
	end

	assign scaled = 32'(phase_q) * 32'(slpg_pkg::FADE_N);
	assign div_dividend = cmd.div_sel ? scaled : now_q;

	slpg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (per_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// fade table folded about its midpoint
	for (genvar g = 0; g < slpg_pkg::ROM_DEPTH; g++) begin : g_rom
		assign fade_rom[g] = slpg_pkg::fade_value(g);
	end

	assign idx = div_quo[slpg_pkg::IDX_W-1:0];
	assign fold = (idx > slpg_pkg::IDX_W'(slpg_pkg::FADE_N / 2))
		? slpg_pkg::IDX_W'(slpg_pkg::FADE_N) - idx : idx;

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			fade_q <= fade_rom[fold[slpg_pkg::ROM_AW-1:0]];
		end
	end

	always_comb begin
		case (mode_q)
			slpg_pkg::MODE_OFF:   level = 8'd0;
			slpg_pkg::MODE_SOLID: level = 8'd255;
			slpg_pkg::MODE_BLINK: level = (phase_q < (per_q >> 1)) ? 8'd255 : 8'd0;
			slpg_pkg::MODE_FADE:  level = fade_q;
			default:              level = 8'd0;
		endcase
		result.drive_enable = (mode_q != slpg_pkg::MODE_OFF);
		result.brightness = level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign sts.mode = mode_q;
	assign sts.div_done = div_done;
	assign sts.out_free = ~out_valid_q | out_ready;

endmodule

[hdl/slpg_ctrl.sv]
`timescale 1ns / 1ps

module slpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output slpg_pkg::ctrl_cmd_t cmd,
	input  slpg_pkg::ctrl_sts_t sts
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_PHASE = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_INDEX = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.mode == slpg_pkg::MODE_BLINK || sts.mode == slpg_pkg::MODE_FADE) begin
					cmd.div_start = 1'b1;
					state_d = ST_PHASE;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_PHASE: begin
				if (sts.div_done) begin
					cmd.save_phase = 1'b1;
					state_d = (sts.mode == slpg_pkg::MODE_FADE) ? ST_SCALE : ST_RESULT;
				end
			end
			ST_SCALE: begin
				// phase is now held, so the scaled dividend is valid
				cmd.div_start = 1'b1;
				cmd.div_sel = 1'b1;
				state_d = ST_INDEX;
			end
			ST_INDEX: begin
				cmd.div_sel = 1'b1;
				if (sts.div_done) begin
					cmd.rom_rd = 1'b1;
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/status_led_pattern_generator_unit.sv]
`timescale 1ns / 1ps

// Status LED pattern generator.
// Input channel (in_valid/in_ready/in_data): one transaction per tick or
// override start; every input transaction yields exactly one output
// transaction on out_valid/out_ready/out_data, in order.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 fast blink period, 1 slow blink period, 2 fade period. Write it
// only while the block is idle.
// Override, override-active and solid items go from the input accept
// through DECODE to RESULT; blink items also pass PHASE, and fade items
// PHASE, SCALE and INDEX; these states use the shared 32-step restoring
// divider (phase = now mod period, then table index).
// One item is in work at a time; the next input is accepted in the cycle
// after the result lands in the output register, even while the receiver
// stalls it.
// A stalled output holds its data and blocks only the following result.
// Reset: periods return to 200/1000/4000 ms, no override window is open
// and the output register is empty.

module status_led_pattern_generator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  slpg_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output slpg_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	slpg_pkg::ctrl_cmd_t cmd;
	slpg_pkg::ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	slpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	slpg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
